FILE: sv/fiie_pkg.sv
// ----------------------------------------------------------------------------
// fiie_pkg
// Shared constants, operation codes and inter-module types of the flux
// interval image encoder.
// ----------------------------------------------------------------------------
package fiie_pkg;

    localparam int MAX_REVS_DEF = 5;

    localparam int NUM_W   = 17;
    localparam int DEN_W   = 20;
    localparam int LIM_W   = 3;
    localparam int OP_W    = 3;
    localparam int TICK_W  = 16;
    localparam int WORD_W  = 16;
    localparam int QUOT_W  = 32;
    localparam int CNT_W   = 32;
    localparam int UNIT_W  = 17;
    localparam int CFG_A_W = 2;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 144;

    localparam logic [NUM_W-1:0]  NUM_RST = 17'd5;
    localparam logic [DEN_W-1:0]  DEN_RST = 20'd3;
    localparam logic [LIM_W-1:0]  LIM_RST = 3'd1;
    localparam logic [UNIT_W-1:0] UNIT_SAT = 17'h1FFFF;

    localparam logic [OP_W-1:0] OP_FLUX        = 3'd0;
    localparam logic [OP_W-1:0] OP_END_REV     = 3'd1;
    localparam logic [OP_W-1:0] OP_BEGIN_TRACK = 3'd2;
    localparam logic [OP_W-1:0] OP_ABORT_TRACK = 3'd3;
    localparam logic [OP_W-1:0] OP_BEGIN_REV   = 3'd4;

    localparam logic [CFG_A_W-1:0] REG_NUM = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_DEN = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_LIM = 2'd2;

    typedef struct packed {
        logic              start;
        logic [QUOT_W-1:0] operand;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
    } scl_req_t;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [QUOT_W-1:0] quot;
    } scl_res_t;

endpackage

FILE: sv/fiie_scaler.sv
// ----------------------------------------------------------------------------
// fiie_scaler
// Scales an operand by num/den: one multiply, an overflow check against
// 2^32, then a restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fiie_scaler
(
    input  logic               clk,
    input  logic               rst_n,
    input  fiie_pkg::scl_req_t req,
    output fiie_pkg::scl_res_t res
);

    localparam int QW = fiie_pkg::QUOT_W;
    localparam int NW = fiie_pkg::NUM_W;
    localparam int DW = fiie_pkg::DEN_W;
    localparam int PW = QW + NW;
    localparam int CW = $clog2(QW);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [QW-1:0] q_reg, q_next;
    logic [NW-1:0] hi_reg, hi_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic          sat_reg, sat_next;

    logic [PW-1:0] prod;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign prod  = q_reg * req.num;
    assign trial = {rem_reg, q_reg[QW-1]};
    assign diff  = trial - {1'b0, req.den};
    assign ge    = trial >= {1'b0, req.den};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        hi_next    = hi_reg;
        rem_next   = rem_reg;
        sat_next   = sat_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    q_next     = req.operand;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                q_next     = prod[QW-1:0];
                hi_next    = prod[PW-1:QW];
                state_next = S_CHK;
            end
            S_CHK:
            begin
                rem_next = DW'(hi_reg);
                cnt_next = '0;
                sat_next = DW'(hi_reg) >= req.den;
                state_next = sat_next ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
                q_next   = {q_reg[QW-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        hi_reg  <= hi_next;
        rem_reg <= rem_next;
        sat_reg <= sat_next;
    end

    assign res.done = state_reg == S_DONE;
    assign res.sat  = sat_reg;
    assign res.quot = q_reg;

endmodule

FILE: sv/flux_interval_image_encoder.sv
// ----------------------------------------------------------------------------
// flux_interval_image_encoder
// Flux and non-refused end-of-revolution requests go through the scaler
// (multiply, check, 32 divide steps unless the scaled value reaches 2^32,
// hand-off, output load); other requests go straight to the output load.
// One request at a time: the next is taken once the last result (a second
// one after a flux overflow word) is loaded, which waits on output stalls.
// Asynchronous active-low reset clears counters and checksum, restores config.
// ----------------------------------------------------------------------------
module flux_interval_image_encoder
#(
    parameter int MAX_REVS = fiie_pkg::MAX_REVS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // operation, interval_ticks, duration_ticks, zero pad
    input  logic [fiie_pkg::S_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // sample_word, duration_units, revolution_samples, track_bytes, checksum
    output logic [fiie_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // status
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            cfg_we,
    input  logic [fiie_pkg::CFG_A_W-1:0]    cfg_index,
    input  logic [fiie_pkg::DEN_W-1:0]      cfg_data
);

    localparam int CW = fiie_pkg::CNT_W;
    localparam int WW = fiie_pkg::WORD_W;
    localparam int UW = fiie_pkg::UNIT_W;
    localparam int LW = fiie_pkg::LIM_W;
    localparam int QW = fiie_pkg::QUOT_W;
    localparam logic [LW-1:0] MaxRevs = LW'(MAX_REVS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_RES_A = 2'd2;
    localparam logic [1:0] ST_RES_B = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [fiie_pkg::OP_W-1:0]    op_reg, op_next;
    logic [UW-1:0]                units_reg, units_next;
    logic [QW-1:0]                dur_reg, dur_next;

    logic [fiie_pkg::NUM_W-1:0]   num_reg;
    logic [fiie_pkg::DEN_W-1:0]   den_reg;
    logic [LW-1:0]                lim_reg;

    logic [CW-1:0] csum_reg, csum_next;
    logic [CW-1:0] snap_reg, snap_next;
    logic [CW-1:0] rsamp_reg, rsamp_next;
    logic [CW-1:0] tbytes_reg, tbytes_next;
    logic [LW-1:0] idx_reg, idx_next;

    logic                          m_valid_reg, m_valid_next;
    logic [fiie_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                          m_user_reg, m_user_next;
    logic                          m_last_reg, m_last_next;

    fiie_pkg::scl_req_t scl_req;
    fiie_pkg::scl_res_t scl_res;

    logic [fiie_pkg::OP_W-1:0]   in_op;
    logic [fiie_pkg::TICK_W-1:0] in_ticks;
    logic [QW-1:0]               in_dticks;
    logic [LW-1:0]               eff_lim;
    logic                        refused;
    logic                        accept;
    logic                        out_free;
    logic                        res_go;
    logic                        ovf_first;
    logic [WW-1:0]               word_fix;
    logic [WW-1:0]               word;
    logic [QW-1:0]               res_dur;
    logic [CW-1:0]               res_rsamp;
    logic                        res_status;
    logic                        res_last;

    assign in_op     = s_axis_tdata[2:0];
    assign in_ticks  = s_axis_tdata[18:3];
    assign in_dticks = s_axis_tdata[50:19];

    assign eff_lim  = (lim_reg > MaxRevs) ? MaxRevs : lim_reg;
    assign refused  = idx_reg >= eff_lim;
    assign s_axis_tready = state_reg == ST_IDLE;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign res_go   = ((state_reg == ST_RES_A) || (state_reg == ST_RES_B)) && out_free;

    assign scl_req.start   = accept && ((in_op == fiie_pkg::OP_FLUX) ||
                             ((in_op == fiie_pkg::OP_END_REV) && !refused));
    assign scl_req.operand = (in_op == fiie_pkg::OP_FLUX) ? QW'(in_ticks) : in_dticks;
    assign scl_req.num     = num_reg;
    assign scl_req.den     = (den_reg == '0) ? fiie_pkg::DEN_W'(1) : den_reg;

    fiie_scaler u_scaler
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scl_req),
        .res   (scl_res)
    );

    assign ovf_first = (state_reg == ST_RES_A) && units_reg[UW-1];
    assign word_fix  = (units_reg[WW-1:0] == '0) ? WW'(1) : units_reg[WW-1:0];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        units_next = units_reg;
        dur_next   = dur_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = in_op;
                    state_next = scl_req.start ? ST_CALC : ST_RES_A;
                end
            end
            ST_CALC:
            begin
                if (scl_res.done)
                begin
                    units_next = (scl_res.sat || (scl_res.quot[QW-1:UW] != '0)) ?
                                 fiie_pkg::UNIT_SAT : scl_res.quot[UW-1:0];
                    dur_next   = scl_res.sat ? '1 : scl_res.quot;
                    state_next = ST_RES_A;
                end
            end
            ST_RES_A:
            begin
                if (res_go)
                begin
                    state_next = ((op_reg == fiie_pkg::OP_FLUX) && units_reg[UW-1]) ?
                                 ST_RES_B : ST_IDLE;
                end
            end
            ST_RES_B:
            begin
                if (res_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result and counter update
    always_comb
    begin
        csum_next   = csum_reg;
        snap_next   = snap_reg;
        rsamp_next  = rsamp_reg;
        tbytes_next = tbytes_reg;
        idx_next    = idx_reg;
        word        = '0;
        res_dur     = '0;
        res_status  = 1'b0;
        res_last    = 1'b1;
        case (op_reg)
            fiie_pkg::OP_FLUX:
            begin
                word        = ovf_first ? '0 : word_fix;
                res_last    = !ovf_first;
                csum_next   = csum_reg + CW'(word[15:8]) + CW'(word[7:0]);
                rsamp_next  = rsamp_reg + CW'(1);
                tbytes_next = tbytes_reg + CW'(2);
            end
            fiie_pkg::OP_END_REV:
            begin
                if (refused)
                begin
                    res_status = 1'b1;
                end
                else
                begin
                    res_dur    = dur_reg;
                    idx_next   = idx_reg + 1'b1;
                    rsamp_next = '0;
                end
            end
            fiie_pkg::OP_BEGIN_TRACK:
            begin
                snap_next   = csum_reg;
                tbytes_next = '0;
                rsamp_next  = '0;
                idx_next    = '0;
            end
            fiie_pkg::OP_ABORT_TRACK:
            begin
                csum_next   = snap_reg;
                tbytes_next = '0;
                rsamp_next  = '0;
                idx_next    = '0;
            end
            fiie_pkg::OP_BEGIN_REV:
            begin
                if (refused)
                begin
                    res_status = 1'b1;
                end
                else
                begin
                    rsamp_next = '0;
                end
            end
            default:
            begin
                res_last = 1'b1;
            end
        endcase
        res_rsamp = (op_reg == fiie_pkg::OP_END_REV) ? rsamp_reg : rsamp_next;
    end

    // output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        if (res_go)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {csum_next, tbytes_next, res_rsamp, res_dur, word};
            m_user_next  = res_status;
            m_last_next  = res_last;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            num_reg     <= fiie_pkg::NUM_RST;
            den_reg     <= fiie_pkg::DEN_RST;
            lim_reg     <= fiie_pkg::LIM_RST;
            csum_reg    <= '0;
            snap_reg    <= '0;
            rsamp_reg   <= '0;
            tbytes_reg  <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    fiie_pkg::REG_NUM: num_reg <= cfg_data[fiie_pkg::NUM_W-1:0];
                    fiie_pkg::REG_DEN: den_reg <= cfg_data;
                    fiie_pkg::REG_LIM: lim_reg <= cfg_data[LW-1:0];
                    default:           num_reg <= num_reg;
                endcase
            end
            if (res_go)
            begin
                csum_reg   <= csum_next;
                snap_reg   <= snap_next;
                rsamp_reg  <= rsamp_next;
                tbytes_reg <= tbytes_next;
                idx_reg    <= idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        units_reg  <= units_next;
        dur_reg    <= dur_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

FILE: sv/fiie_checker.sv
// ----------------------------------------------------------------------------
// fiie_checker
// Port-level checks of the flux interval image encoder, bound to the top.
// ----------------------------------------------------------------------------
module fiie_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [fiie_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          m_axis_tlast
);

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // one request in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // a refusal ends the request and carries no sample or duration
    a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tlast && (m_axis_tdata[47:0] == 48'd0))
        else $error("malformed refusal");

    // only an overflow word precedes a further result
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            (m_axis_tdata[15:0] == 16'd0) && (m_axis_tdata[47:16] == 32'd0) &&
            !m_axis_tuser)
        else $error("non-final result is not an overflow word");

endmodule

bind flux_interval_image_encoder fiie_checker u_fiie_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
